>>> hdl/assert_macros.svh
// Assertion macros used by the RTL file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ecpsm_pkg.sv
// Types and constants of the elliptic curve point scalar multiplier.
package ecpsm_pkg;

  localparam int unsigned DATA_BITS    = 64;
  localparam int unsigned CFG_IDX_BITS = 1;

  localparam logic [CFG_IDX_BITS-1:0] CFG_MODULUS = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE_A = 1'd1;

  localparam logic CMD_SCALE = 1'b0;
  localparam logic CMD_ADD   = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [DATA_BITS-1:0] point_x;
    logic [DATA_BITS-1:0] point_y;
    logic [DATA_BITS-1:0] second_x;
    logic [DATA_BITS-1:0] second_y;
    logic [DATA_BITS-1:0] scalar;
  } in_item_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] result_x;
    logic [DATA_BITS-1:0] result_y;
  } out_item_t;

  // Operations of the shared modular unit.
  typedef enum logic [1:0] {
    U_ADD,
    U_SUB,
    U_MUL,
    U_DIV
  } uop_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_RCA,
    ST_RQX,
    ST_RQY,
    ST_RRX,
    ST_RRY,
    ST_SINIT,
    ST_SLOOP,
    ST_SNEXT,
    ST_ACHK,
    ST_A1,
    ST_A2,
    ST_DCHK,
    ST_D1,
    ST_D2,
    ST_D3,
    ST_D4,
    ST_D5,
    ST_IV0,
    ST_IVL,
    ST_IVD,
    ST_IVM,
    ST_IVS,
    ST_IVE,
    ST_T1,
    ST_T2,
    ST_T3,
    ST_T4,
    ST_T5,
    ST_T6,
    ST_T7,
    ST_RET,
    ST_DONE
  } st_t;

endpackage

>>> hdl/ec_point_scalar_multiply.sv
// Affine elliptic curve point add and scalar multiply over a prime field.
//
// Usage: configure modulus (index 0) and curve_a (index 1) through the cfg
// write port while the block is idle. An item is transferred at a rising edge
// with start high and busy low; busy then stays high until the result is out.
// cmd 1 adds (point_x, point_y) and (second_x, second_y); cmd 0 multiplies the
// first point by scalar with right-to-left double-and-add. (0,0) is infinity.
// The result appears on out_item for exactly one cycle with out_valid high;
// the receiver cannot stall it, so it must take it in that cycle.
// All arithmetic runs on one shared modular unit, one step a cycle: add,
// subtract, double-and-add multiply and long divide. Inputs are first reduced
// by the modulus. Each point operation needs one inverse by extended Euclid,
// plus up to four multiplies. A scalar multiply runs up to 2*SCALAR_BITS point
// operations.
// Reset returns the block to idle with modulus 17 and curve_a 2.
`include "assert_macros.svh"

module ec_point_scalar_multiply #(
  parameter int unsigned FIELD_BITS  = 64,
  parameter int unsigned SCALAR_BITS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  ecpsm_pkg::in_item_t                 in_item,
  output logic                                out_valid,
  output ecpsm_pkg::out_item_t                out_item,
  input  logic                                cfg_we,
  input  logic [ecpsm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ecpsm_pkg::DATA_BITS-1:0]     cfg_data
);

  localparam int unsigned W  = FIELD_BITS;
  localparam int unsigned SB = SCALAR_BITS;
  localparam int unsigned CW = $clog2(W + 1);

  function automatic logic [W-1:0] madd(logic [W-1:0] x, logic [W-1:0] y,
                                        logic [W-1:0] p);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] msub(logic [W-1:0] x, logic [W-1:0] y,
                                        logic [W-1:0] p);
    logic [W-1:0] d;
    if (x >= y) d = x - y;
    else d = x + (p - y);
    return d;
  endfunction

  // Configuration registers
  logic [W-1:0] modulus_r, curve_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= W'(17);
      curve_a_r <= W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        ecpsm_pkg::CFG_MODULUS: modulus_r <= cfg_data[W-1:0];
        ecpsm_pkg::CFG_CURVE_A: curve_a_r <= cfg_data[W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer state and working registers
  ecpsm_pkg::st_t state_r, state_nxt;
  logic iss_r;
  logic cmd_r, dst_r, dbl_r, in_add_r;
  logic [SB-1:0] k_r;
  logic [W-1:0] ca_r, rx_r, ry_r, qx_r, qy_r;
  logic [W-1:0] ex_r, fx_r, gy_r, nm_r, iv_r, s_r, tm_r;
  logic [W-1:0] r0_r, r1_r, t0_r, t1_r, qq_r, r2_r;

  // Shared modular unit
  logic              u_go;
  ecpsm_pkg::uop_t   u_op, u_op_r;
  logic [W-1:0]      u_a, u_b;
  logic [W-1:0]      u_a_r, u_b_r, u_acc_r, u_quo_r;
  logic [CW-1:0]     u_cnt_r;
  logic              u_ph_r, u_busy_r, u_done_r;
  logic [W:0]        u_trial;

  assign u_trial = {u_acc_r, u_b_r[W-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u_busy_r <= 1'b0;
      u_done_r <= 1'b0;
    end else begin
      u_done_r <= 1'b0;
      if (u_go) begin
        u_op_r  <= u_op;
        u_cnt_r <= CW'(W);
        u_ph_r  <= 1'b0;
        u_quo_r <= '0;
        case (u_op)
          ecpsm_pkg::U_ADD: begin
            u_acc_r  <= madd(u_a, u_b, modulus_r);
            u_done_r <= 1'b1;
          end
          ecpsm_pkg::U_SUB: begin
            u_acc_r  <= msub(u_a, u_b, modulus_r);
            u_done_r <= 1'b1;
          end
          ecpsm_pkg::U_MUL: begin
            u_acc_r  <= '0;
            u_a_r    <= u_a;
            u_b_r    <= u_b;
            u_busy_r <= 1'b1;
          end
          default: begin
            // Divide: u_b_r shifts the dividend out, u_a_r holds the divisor.
            u_acc_r  <= '0;
            u_a_r    <= u_b;
            u_b_r    <= u_a;
            u_busy_r <= 1'b1;
          end
        endcase
      end else if (u_busy_r) begin
        case (u_op_r)
          ecpsm_pkg::U_MUL: begin
            if (!u_ph_r) begin
              u_acc_r <= madd(u_acc_r, u_acc_r, modulus_r);
              u_ph_r  <= 1'b1;
            end else begin
              if (u_b_r[W-1]) u_acc_r <= madd(u_acc_r, u_a_r, modulus_r);
              u_b_r   <= u_b_r << 1;
              u_ph_r  <= 1'b0;
              u_cnt_r <= u_cnt_r - CW'(1);
              if (u_cnt_r == CW'(1)) begin
                u_busy_r <= 1'b0;
                u_done_r <= 1'b1;
              end
            end
          end
          default: begin
            if (u_trial >= {1'b0, u_a_r}) begin
              u_acc_r <= W'(u_trial - {1'b0, u_a_r});
              u_quo_r <= {u_quo_r[W-2:0], 1'b1};
            end else begin
              u_acc_r <= u_trial[W-1:0];
              u_quo_r <= {u_quo_r[W-2:0], 1'b0};
            end
            u_b_r   <= u_b_r << 1;
            u_cnt_r <= u_cnt_r - CW'(1);
            if (u_cnt_r == CW'(1)) begin
              u_busy_r <= 1'b0;
              u_done_r <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Conditions on the working points
  logic         accept, fin;
  logic         r_inf, q_inf, x_eq, y_opp, y_eq;
  logic [W-1:0] qy_neg;

  assign accept = start && !busy;
  assign fin    = iss_r && u_done_r;
  assign r_inf  = (rx_r == '0) && (ry_r == '0);
  assign q_inf  = (qx_r == '0) && (qy_r == '0);
  assign qy_neg = (qy_r == '0) ? '0 : (modulus_r - qy_r);
  assign x_eq   = (rx_r == qx_r);
  assign y_opp  = (ry_r == qy_neg);
  assign y_eq   = (ry_r == qy_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ecpsm_pkg::ST_IDLE:
        if (accept) state_nxt = (modulus_r == '0) ? ecpsm_pkg::ST_DONE : ecpsm_pkg::ST_RCA;
      ecpsm_pkg::ST_RCA: if (fin) state_nxt = ecpsm_pkg::ST_RQX;
      ecpsm_pkg::ST_RQX: if (fin) state_nxt = ecpsm_pkg::ST_RQY;
      ecpsm_pkg::ST_RQY:
        if (fin) state_nxt = cmd_r ? ecpsm_pkg::ST_RRX : ecpsm_pkg::ST_SINIT;
      ecpsm_pkg::ST_RRX: if (fin) state_nxt = ecpsm_pkg::ST_RRY;
      ecpsm_pkg::ST_RRY: if (fin) state_nxt = ecpsm_pkg::ST_ACHK;
      ecpsm_pkg::ST_SINIT: state_nxt = ecpsm_pkg::ST_SLOOP;
      ecpsm_pkg::ST_SLOOP:
        state_nxt = (k_r == '0) ? ecpsm_pkg::ST_DONE : ecpsm_pkg::ST_DCHK;
      ecpsm_pkg::ST_SNEXT: state_nxt = ecpsm_pkg::ST_SLOOP;
      ecpsm_pkg::ST_ACHK: begin
        if (r_inf || q_inf || (x_eq && y_opp)) state_nxt = ecpsm_pkg::ST_RET;
        else if (x_eq && y_eq) state_nxt = ecpsm_pkg::ST_DCHK;
        else state_nxt = ecpsm_pkg::ST_A1;
      end
      ecpsm_pkg::ST_A1: if (fin) state_nxt = ecpsm_pkg::ST_IV0;
      ecpsm_pkg::ST_A2: if (fin) state_nxt = ecpsm_pkg::ST_T1;
      ecpsm_pkg::ST_DCHK:
        state_nxt = (qy_r == '0) ? ecpsm_pkg::ST_RET : ecpsm_pkg::ST_D1;
      ecpsm_pkg::ST_D1: if (fin) state_nxt = ecpsm_pkg::ST_IV0;
      ecpsm_pkg::ST_D2: if (fin) state_nxt = ecpsm_pkg::ST_D3;
      ecpsm_pkg::ST_D3: if (fin) state_nxt = ecpsm_pkg::ST_D4;
      ecpsm_pkg::ST_D4: if (fin) state_nxt = ecpsm_pkg::ST_D5;
      ecpsm_pkg::ST_D5: if (fin) state_nxt = ecpsm_pkg::ST_T1;
      ecpsm_pkg::ST_IV0: state_nxt = ecpsm_pkg::ST_IVL;
      ecpsm_pkg::ST_IVL:
        state_nxt = (r1_r == '0) ? ecpsm_pkg::ST_IVE : ecpsm_pkg::ST_IVD;
      ecpsm_pkg::ST_IVD: if (fin) state_nxt = ecpsm_pkg::ST_IVM;
      ecpsm_pkg::ST_IVM: if (fin) state_nxt = ecpsm_pkg::ST_IVS;
      ecpsm_pkg::ST_IVS: if (fin) state_nxt = ecpsm_pkg::ST_IVL;
      ecpsm_pkg::ST_IVE: state_nxt = dbl_r ? ecpsm_pkg::ST_D2 : ecpsm_pkg::ST_A2;
      ecpsm_pkg::ST_T1: if (fin) state_nxt = ecpsm_pkg::ST_T2;
      ecpsm_pkg::ST_T2: if (fin) state_nxt = ecpsm_pkg::ST_T3;
      ecpsm_pkg::ST_T3: if (fin) state_nxt = ecpsm_pkg::ST_T4;
      ecpsm_pkg::ST_T4: if (fin) state_nxt = ecpsm_pkg::ST_T5;
      ecpsm_pkg::ST_T5: if (fin) state_nxt = ecpsm_pkg::ST_T6;
      ecpsm_pkg::ST_T6: if (fin) state_nxt = ecpsm_pkg::ST_T7;
      ecpsm_pkg::ST_T7: if (fin) state_nxt = ecpsm_pkg::ST_RET;
      ecpsm_pkg::ST_RET: begin
        // After a doubling in the scalar loop, an add follows when the bit is set.
        if (cmd_r == ecpsm_pkg::CMD_ADD) state_nxt = ecpsm_pkg::ST_DONE;
        else if (in_add_r) state_nxt = ecpsm_pkg::ST_SNEXT;
        else if (k_r[0]) state_nxt = ecpsm_pkg::ST_ACHK;
        else state_nxt = ecpsm_pkg::ST_SNEXT;
      end
      ecpsm_pkg::ST_DONE: state_nxt = ecpsm_pkg::ST_IDLE;
      default: state_nxt = ecpsm_pkg::ST_IDLE;
    endcase
  end

  // Unit commands and channel outputs
  logic u_req;

  always_comb begin
    u_req = 1'b1;
    u_op  = ecpsm_pkg::U_ADD;
    u_a   = '0;
    u_b   = '0;
    case (state_r)
      ecpsm_pkg::ST_RCA: begin u_op = ecpsm_pkg::U_DIV; u_a = curve_a_r; u_b = modulus_r; end
      ecpsm_pkg::ST_RQX: begin u_op = ecpsm_pkg::U_DIV; u_a = qx_r; u_b = modulus_r; end
      ecpsm_pkg::ST_RQY: begin u_op = ecpsm_pkg::U_DIV; u_a = qy_r; u_b = modulus_r; end
      ecpsm_pkg::ST_RRX: begin u_op = ecpsm_pkg::U_DIV; u_a = rx_r; u_b = modulus_r; end
      ecpsm_pkg::ST_RRY: begin u_op = ecpsm_pkg::U_DIV; u_a = ry_r; u_b = modulus_r; end
      ecpsm_pkg::ST_A1:  begin u_op = ecpsm_pkg::U_SUB; u_a = rx_r; u_b = qx_r; end
      ecpsm_pkg::ST_A2:  begin u_op = ecpsm_pkg::U_SUB; u_a = ry_r; u_b = qy_r; end
      ecpsm_pkg::ST_D1:  begin u_op = ecpsm_pkg::U_ADD; u_a = qy_r; u_b = qy_r; end
      ecpsm_pkg::ST_D2:  begin u_op = ecpsm_pkg::U_MUL; u_a = qx_r; u_b = qx_r; end
      ecpsm_pkg::ST_D3:  begin u_op = ecpsm_pkg::U_ADD; u_a = nm_r; u_b = nm_r; end
      ecpsm_pkg::ST_D4:  begin u_op = ecpsm_pkg::U_ADD; u_a = tm_r; u_b = nm_r; end
      ecpsm_pkg::ST_D5:  begin u_op = ecpsm_pkg::U_ADD; u_a = nm_r; u_b = ca_r; end
      ecpsm_pkg::ST_IVD: begin u_op = ecpsm_pkg::U_DIV; u_a = r0_r; u_b = r1_r; end
      ecpsm_pkg::ST_IVM: begin u_op = ecpsm_pkg::U_MUL; u_a = t1_r; u_b = qq_r; end
      ecpsm_pkg::ST_IVS: begin u_op = ecpsm_pkg::U_SUB; u_a = t0_r; u_b = tm_r; end
      ecpsm_pkg::ST_T1:  begin u_op = ecpsm_pkg::U_MUL; u_a = nm_r; u_b = iv_r; end
      ecpsm_pkg::ST_T2:  begin u_op = ecpsm_pkg::U_MUL; u_a = s_r;  u_b = s_r; end
      ecpsm_pkg::ST_T3:  begin u_op = ecpsm_pkg::U_SUB; u_a = tm_r; u_b = ex_r; end
      ecpsm_pkg::ST_T4:  begin u_op = ecpsm_pkg::U_SUB; u_a = tm_r; u_b = fx_r; end
      ecpsm_pkg::ST_T5:  begin u_op = ecpsm_pkg::U_SUB; u_a = ex_r; u_b = tm_r; end
      ecpsm_pkg::ST_T6:  begin u_op = ecpsm_pkg::U_MUL; u_a = s_r;  u_b = nm_r; end
      ecpsm_pkg::ST_T7:  begin u_op = ecpsm_pkg::U_SUB; u_a = nm_r; u_b = gy_r; end
      default: u_req = 1'b0;
    endcase
    u_go      = u_req && !iss_r;
    busy      = (state_r != ecpsm_pkg::ST_IDLE);
    out_valid = (state_r == ecpsm_pkg::ST_DONE);
    out_item.result_x = ecpsm_pkg::DATA_BITS'(rx_r);
    out_item.result_y = ecpsm_pkg::DATA_BITS'(ry_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ecpsm_pkg::ST_IDLE;
      iss_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (u_go) iss_r <= 1'b1;
      else if (fin) iss_r <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state_r)
      ecpsm_pkg::ST_IDLE: begin
        if (accept) begin
          cmd_r <= in_item.cmd;
          k_r   <= in_item.scalar[SB-1:0];
          if (in_item.cmd == ecpsm_pkg::CMD_ADD) begin
            rx_r <= in_item.point_x[W-1:0];
            ry_r <= in_item.point_y[W-1:0];
            qx_r <= in_item.second_x[W-1:0];
            qy_r <= in_item.second_y[W-1:0];
          end else begin
            qx_r <= in_item.point_x[W-1:0];
            qy_r <= in_item.point_y[W-1:0];
          end
          if (modulus_r == '0) begin
            rx_r <= '0;
            ry_r <= '0;
          end
        end
      end
      ecpsm_pkg::ST_RCA: if (fin) ca_r <= u_acc_r;
      ecpsm_pkg::ST_RQX: if (fin) qx_r <= u_acc_r;
      ecpsm_pkg::ST_RQY: if (fin) qy_r <= u_acc_r;
      ecpsm_pkg::ST_RRX: if (fin) rx_r <= u_acc_r;
      ecpsm_pkg::ST_RRY: if (fin) ry_r <= u_acc_r;
      ecpsm_pkg::ST_SINIT: begin
        rx_r <= k_r[0] ? qx_r : '0;
        ry_r <= k_r[0] ? qy_r : '0;
        k_r  <= k_r >> 1;
      end
      ecpsm_pkg::ST_SLOOP: begin
        dst_r    <= 1'b0;
        in_add_r <= 1'b0;
      end
      ecpsm_pkg::ST_SNEXT: begin
        k_r      <= k_r >> 1;
        in_add_r <= 1'b0;
      end
      ecpsm_pkg::ST_ACHK: begin
        in_add_r <= 1'b1;
        if (r_inf) begin
          rx_r <= qx_r;
          ry_r <= qy_r;
        end else if (q_inf) begin
          rx_r <= rx_r;
        end else if (x_eq && y_opp) begin
          rx_r <= '0;
          ry_r <= '0;
        end else if (x_eq && y_eq) begin
          dst_r <= 1'b1;
        end else begin
          ex_r  <= rx_r;
          fx_r  <= qx_r;
          gy_r  <= ry_r;
          dbl_r <= 1'b0;
        end
      end
      ecpsm_pkg::ST_DCHK: begin
        if (qy_r == '0) begin
          if (dst_r) begin
            rx_r <= '0;
            ry_r <= '0;
          end else begin
            qx_r <= '0;
            qy_r <= '0;
          end
        end else begin
          ex_r  <= qx_r;
          fx_r  <= qx_r;
          gy_r  <= qy_r;
          dbl_r <= 1'b1;
        end
      end
      ecpsm_pkg::ST_A1: if (fin) iv_r <= u_acc_r;
      ecpsm_pkg::ST_D1: if (fin) iv_r <= u_acc_r;
      ecpsm_pkg::ST_IV0: begin
        r0_r <= modulus_r;
        r1_r <= iv_r;
        t0_r <= '0;
        t1_r <= (modulus_r == W'(1)) ? '0 : W'(1);
      end
      ecpsm_pkg::ST_IVD: if (fin) begin
        qq_r <= u_quo_r;
        r2_r <= u_acc_r;
      end
      ecpsm_pkg::ST_IVM: if (fin) tm_r <= u_acc_r;
      ecpsm_pkg::ST_IVS: if (fin) begin
        t0_r <= t1_r;
        t1_r <= u_acc_r;
        r0_r <= r1_r;
        r1_r <= r2_r;
      end
      // A denominator with no inverse gives zero.
      ecpsm_pkg::ST_IVE: iv_r <= (r0_r == W'(1)) ? t0_r : '0;
      ecpsm_pkg::ST_A2: if (fin) nm_r <= u_acc_r;
      ecpsm_pkg::ST_D2: if (fin) nm_r <= u_acc_r;
      ecpsm_pkg::ST_D3: if (fin) tm_r <= u_acc_r;
      ecpsm_pkg::ST_D4: if (fin) nm_r <= u_acc_r;
      ecpsm_pkg::ST_D5: if (fin) nm_r <= u_acc_r;
      ecpsm_pkg::ST_T1: if (fin) s_r <= u_acc_r;
      ecpsm_pkg::ST_T2: if (fin) tm_r <= u_acc_r;
      ecpsm_pkg::ST_T3: if (fin) tm_r <= u_acc_r;
      ecpsm_pkg::ST_T4: if (fin) tm_r <= u_acc_r;
      ecpsm_pkg::ST_T5: if (fin) nm_r <= u_acc_r;
      ecpsm_pkg::ST_T6: if (fin) nm_r <= u_acc_r;
      // A sum always lands in the running point; a doubling lands there only
      // when it stands in for an add of equal points.
      ecpsm_pkg::ST_T7: if (fin) begin
        if (dst_r || !dbl_r) begin
          rx_r <= tm_r;
          ry_r <= u_acc_r;
        end else begin
          qx_r <= tm_r;
          qy_r <= u_acc_r;
        end
      end
      default: ;
    endcase
  end

  `CHK_NEXT(a_out_one_cycle, clk, rst_n, out_valid, !out_valid, "result held over one cycle")
  `CHK_NEXT(a_busy_after_start, clk, rst_n, accept, busy, "not busy after a transfer")
  `CHK_NEXT(a_unit_done_pulse, clk, rst_n, u_done_r, !u_done_r, "unit done on two cycles")

endmodule
